@@ rtl/flash_phrase_program_sequencer_defines.svh @@
// Assertion macros for the flash phrase program sequencer RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef FLASH_PHRASE_PROGRAM_SEQUENCER_DEFINES_SVH
`define FLASH_PHRASE_PROGRAM_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FPPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fpps_pkg.sv @@
// Package for the flash phrase program sequencer: codes, constants, job type.
// No dependencies; imported by every module of the block.
`default_nettype none

package fpps_pkg;

    // Field widths
    localparam int ADDR_W = 24;
    localparam int WORD_W = 32;
    localparam int STEP_W = 4;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Flash register selects
    localparam logic [1:0] SEL_INDEX  = 2'd0;
    localparam logic [1:0] SEL_STATUS = 2'd1;
    localparam logic [1:0] SEL_HIGH   = 2'd2;
    localparam logic [1:0] SEL_LOW    = 2'd3;

    // Status bits and command bytes
    localparam int         ST_READY_BIT  = 7;
    localparam int         ST_ACCERR_BIT = 5;
    localparam int         ST_FPVIOL_BIT = 4;
    localparam logic [7:0] ST_LAUNCH     = 8'h80;
    localparam logic [7:0] ST_ERRORS     = 8'h30;
    localparam logic [7:0] CMD_PROGRAM   = 8'h06;
    localparam logic [7:0] IDX_ADDR_HI   = 8'd0;
    localparam logic [7:0] IDX_ADDR_LO   = 8'd1;
    localparam logic [7:0] IDX_WORD0     = 8'd2;
    localparam logic [7:0] IDX_WORD1     = 8'd4;
    localparam logic [ADDR_W-1:0] PHRASE_STEP = 24'd8;

    // Step positions inside a program run
    localparam logic [STEP_W-1:0] STEP_WORD_BASE   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_WORD_END    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAUNCH_READ = 4'd13;

    // Sequencer phase
    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SECOND = 3'd2,
        PH_POLL   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // Kind of job handed from front to back
    typedef enum logic [1:0] {
        JOB_POLL  = 2'd0,
        JOB_CLEAR = 2'd1,
        JOB_DONE  = 2'd2,
        JOB_RUN   = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic               has_addr;
        logic               launch;
        logic               fail;
        logic [ADDR_W-1:0]  addr;
        logic [WORD_W-1:0]  word;
    } job_t;

endpackage

`default_nettype wire

@@ rtl/flash_phrase_program_sequencer.sv @@
// Flash phrase program sequencer: accepts data words and status bytes on a
// slave stream and issues flash bus accesses on a master stream.
// Channels: s_* carries input items (tuser = func: 0 data word, 1 status byte;
// tlast = last word of the block). m_* carries one bus access per item
// (tuser = read request, tlast = last access caused by that input item).
// cfg_wen/cfg_wdata write start_address; write it only while the block is idle.
// With the job queue empty, the first access of an input item appears
// the cycle after the item is accepted. The back end issues one access per
// cycle while m_tready is high, so an item causes 0 to 14 accesses: 14 for a
// launched first word with address, 12 without launch, 8 for a second word,
// 1 for a status poll, clear or completion.
// Inputs are taken back to back while the job queue (QUEUE_DEPTH jobs) has
// room; a stalled m_tready holds the current access and fills the queue, after
// which s_tready drops.
// Reset: the initial status read counts as already requested; the first item
// expected is a status byte. Queue and sequencer return to empty and initial.
// Depends on fpps_pkg, fpps_front, fpps_queue and fpps_back.
`default_nettype none

module flash_phrase_program_sequencer #(
    parameter int QUEUE_DEPTH = fpps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [fpps_pkg::ADDR_W-1:0] cfg_wdata,   // start_address
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [39:0]                s_tdata,      // data_word[31:0],
                                                          // status_byte[39:32]
    input  wire logic                       s_tuser,      // func
    input  wire logic                       s_tlast,      // last_word
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,      // reg_select[1:0],
                                                          // write_byte[9:2],
                                                          // finished[10],
                                                          // failed[11], pad
    output logic                            m_tuser,      // is_read
    output logic                            m_tlast       // run_last
);
    import fpps_pkg::*;

    logic in_accept;
    logic push;
    logic full;
    logic pop;
    logic empty;
    job_t push_job;
    job_t head_job;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    // Classify incoming items
    fpps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_accept   (in_accept),
        .func        (s_tuser),
        .data_word   (s_tdata[31:0]),
        .last_word   (s_tlast),
        .status_byte (s_tdata[39:32]),
        .push        (push),
        .push_job    (push_job)
    );

    // Buffer jobs between front and back
    fpps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    // Expand jobs into bus accesses
    fpps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/fpps_front.sv @@
// Front end: accepts input items, tracks the sequencer phase and emits jobs.
// Depends on fpps_pkg.
`default_nettype none

module fpps_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [fpps_pkg::ADDR_W-1:0] cfg_wdata,
    input  wire logic                       in_accept,
    input  wire logic                       func,
    input  wire logic [fpps_pkg::WORD_W-1:0] data_word,
    input  wire logic                       last_word,
    input  wire logic [7:0]                 status_byte,
    output logic                            push,
    output fpps_pkg::job_t                  push_job
);
    import fpps_pkg::*;

    logic [ADDR_W-1:0] start_address_reg;
    phase_t            phase_reg, phase_next;
    logic [ADDR_W-1:0] phrase_address_reg, phrase_address_next;
    logic              block_ending_reg, block_ending_next;

    logic st_ready;
    logic st_error;

    assign st_ready = status_byte[ST_READY_BIT];
    assign st_error = status_byte[ST_ACCERR_BIT] | status_byte[ST_FPVIOL_BIT];

    // Hold the start address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= '0;
        end
        else if (cfg_wen)
        begin
            start_address_reg <= cfg_wdata;
        end
    end

    // Advance phase and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_INIT;
            phrase_address_reg <= '0;
            block_ending_reg   <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            phrase_address_reg <= phrase_address_next;
            block_ending_reg   <= block_ending_next;
        end
    end

    // Classify the accepted item and build its job
    always_comb
    begin
        phase_next          = phase_reg;
        phrase_address_next = phrase_address_reg;
        block_ending_next   = block_ending_reg;
        push                = 1'b0;
        push_job.kind       = JOB_POLL;
        push_job.has_addr   = 1'b0;
        push_job.launch     = 1'b0;
        push_job.fail       = 1'b0;
        push_job.addr       = phrase_address_reg;
        push_job.word       = data_word;
        if (in_accept)
        begin
            case (phase_reg)
                PH_INIT:
                begin
                    if (func)
                    begin
                        if (!st_ready)
                        begin
                            push = 1'b1;
                        end
                        else
                        begin
                            push                = st_error;
                            push_job.kind       = JOB_CLEAR;
                            phrase_address_next = start_address_reg;
                            block_ending_next   = 1'b0;
                            phase_next          = PH_FIRST;
                        end
                    end
                end
                PH_FIRST:
                begin
                    if (!func)
                    begin
                        push              = 1'b1;
                        push_job.kind     = JOB_RUN;
                        push_job.has_addr = 1'b1;
                        push_job.launch   = last_word;
                        if (last_word)
                        begin
                            phrase_address_next = phrase_address_reg + PHRASE_STEP;
                            block_ending_next   = 1'b1;
                            phase_next          = PH_POLL;
                        end
                        else
                        begin
                            phase_next = PH_SECOND;
                        end
                    end
                end
                PH_SECOND:
                begin
                    if (!func)
                    begin
                        push                = 1'b1;
                        push_job.kind       = JOB_RUN;
                        push_job.launch     = 1'b1;
                        phrase_address_next = phrase_address_reg + PHRASE_STEP;
                        block_ending_next   = last_word;
                        phase_next          = PH_POLL;
                    end
                end
                PH_POLL:
                begin
                    if (func)
                    begin
                        if (!st_ready)
                        begin
                            push = 1'b1;
                        end
                        else if (st_error || block_ending_reg)
                        begin
                            push          = 1'b1;
                            push_job.kind = JOB_DONE;
                            push_job.fail = st_error;
                            phase_next    = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/fpps_queue.sv @@
// Job queue between the front and back ends of the sequencer.
// Depends on fpps_pkg for the job type.
`default_nettype none

module fpps_queue #(
    parameter int DEPTH = fpps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fpps_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output fpps_pkg::job_t      head_job,
    output logic                empty
);
    import fpps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    // Wrap pointers and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fpps_back.sv @@
// Back end: expands the job at the queue head into its bus accesses.
// Depends on fpps_pkg and the assertion macros header.
`default_nettype none

`include "flash_phrase_program_sequencer_defines.svh"

module fpps_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fpps_pkg::job_t head_job,
    input  wire logic           empty,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,   // reg_select[1:0], write_byte[9:2],
                                           // finished[10], failed[11], zero pad
    output logic                m_tuser,   // is_read
    output logic                m_tlast    // run_last
);
    import fpps_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] run_step;
    logic [7:0]        word_idx;
    logic [1:0]        reg_select;
    logic [7:0]        write_byte;
    logic              finished;
    logic              failed;
    logic              is_read;
    logic              run_last;
    logic              out_accept;

    assign m_tvalid   = !empty;
    assign out_accept = m_tvalid && m_tready;
    assign pop        = out_accept && run_last;
    assign run_step   = head_job.has_addr ? step_reg : step_reg + STEP_WORD_BASE;
    assign word_idx   = head_job.has_addr ? IDX_WORD0 : IDX_WORD1;

    // Select the access for the current step
    always_comb
    begin
        is_read    = 1'b0;
        reg_select = SEL_STATUS;
        write_byte = 8'h00;
        finished   = 1'b0;
        failed     = 1'b0;
        run_last   = 1'b1;
        case (head_job.kind)
            JOB_POLL:
            begin
                is_read = 1'b1;
            end
            JOB_CLEAR:
            begin
                write_byte = ST_ERRORS;
            end
            JOB_DONE:
            begin
                finished = 1'b1;
                failed   = head_job.fail;
            end
            JOB_RUN:
            begin
                run_last = (run_step == (head_job.launch ? STEP_LAUNCH_READ : STEP_WORD_END));
                case (run_step)
                    4'd0:
                    begin
                        reg_select = SEL_INDEX;
                        write_byte = IDX_ADDR_HI;
                    end
                    4'd1:
                    begin
                        reg_select = SEL_HIGH;
                        write_byte = CMD_PROGRAM;
                    end
                    4'd2:
                    begin
                        reg_select = SEL_LOW;
                        write_byte = head_job.addr[23:16];
                    end
                    4'd3:
                    begin
                        reg_select = SEL_INDEX;
                        write_byte = IDX_ADDR_LO;
                    end
                    4'd4:
                    begin
                        reg_select = SEL_HIGH;
                        write_byte = head_job.addr[15:8];
                    end
                    4'd5:
                    begin
                        reg_select = SEL_LOW;
                        write_byte = head_job.addr[7:0];
                    end
                    4'd6:
                    begin
                        reg_select = SEL_INDEX;
                        write_byte = word_idx;
                    end
                    4'd7:
                    begin
                        reg_select = SEL_HIGH;
                        write_byte = head_job.word[15:8];
                    end
                    4'd8:
                    begin
                        reg_select = SEL_LOW;
                        write_byte = head_job.word[7:0];
                    end
                    4'd9:
                    begin
                        reg_select = SEL_INDEX;
                        write_byte = word_idx + 8'd1;
                    end
                    4'd10:
                    begin
                        reg_select = SEL_HIGH;
                        write_byte = head_job.word[31:24];
                    end
                    4'd11:
                    begin
                        reg_select = SEL_LOW;
                        write_byte = head_job.word[23:16];
                    end
                    4'd12:
                    begin
                        write_byte = ST_LAUNCH;
                    end
                    default:
                    begin
                        is_read = 1'b1;
                    end
                endcase
            end
            default:
            begin
                run_last = 1'b1;
            end
        endcase
    end

    // Advance within the job, restart on its last access
    always_comb
    begin
        step_next = step_reg;
        if (out_accept)
        begin
            step_next = run_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign m_tdata = {4'b0000, failed, finished, write_byte, reg_select};
    assign m_tuser = is_read;
    assign m_tlast = run_last;

    `FPPS_ASSERT_NEXT(a_run_continues, out_accept && !m_tlast,
        m_tvalid && step_reg == $past(step_reg) + 1'b1, "run interrupted mid-job")
    `FPPS_ASSERT_NOW(a_finish_is_last, m_tvalid && m_tdata[10], m_tlast,
        "completion access not last of its job")
    `FPPS_ASSERT_NOW(a_read_is_last, m_tvalid && m_tuser, m_tlast,
        "status read not last of its job")

endmodule

`default_nettype wire

@@ verif/flash_phrase_program_sequencer_tb.sv @@
// Testbench for flash_phrase_program_sequencer: streams data words and status bytes,
// predicts every flash bus access in its own sequencer model and checks them in order.
// Depends on fpps_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 100ps

module flash_phrase_program_sequencer_tb;

    import fpps_pkg::*;

    localparam int         CLK_PERIOD   = 12;
    localparam int         MAX_IDLE     = 18;
    localparam int         RANDOM_ITEMS = 210;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         STALL_LIMIT  = 2000;
    localparam logic       FUNC_DATA    = 1'b0;
    localparam logic       FUNC_STATUS  = 1'b1;
    localparam logic [7:0] ST_NONE      = 8'h00;

    // How the block is brought to its end
    typedef enum int {
        END_ODD_WORD,
        END_WORD_PAIR,
        END_ERROR
    } block_end_t;

    // One flash bus access as seen on the master stream
    typedef struct packed {
        logic       is_read;
        logic [1:0] reg_select;
        logic [7:0] write_byte;
        logic       run_last;
        logic       finished;
        logic       failed;
    } bus_access_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [ADDR_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // Sequencer copy kept by the predictor
    phase_t              seq_phase;
    logic [ADDR_W-1:0]   seq_addr;
    logic                seq_ending;
    logic [ADDR_W-1:0]   cfg_start;

    bus_access_t         item_accesses[$];
    bus_access_t         expected_accesses[$];

    bit                  no_idle;
    int                  mismatch_count;
    int                  items_accepted;
    int                  accesses_checked;
    block_end_t          end_kind;
    logic                end_failed;

    flash_phrase_program_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Stage one access of the current input item
    function automatic void add_access(logic rd, logic [1:0] sel, logic [7:0] value,
                                       logic fin, logic fail);
        bus_access_t acc;
        acc.is_read    = rd;
        acc.reg_select = sel;
        acc.write_byte = value;
        acc.run_last   = 1'b0;
        acc.finished   = fin;
        acc.failed     = fail;
        item_accesses.push_back(acc);
    endfunction

    // Write one data word through two command index slots, low half first
    function automatic void add_word(logic [7:0] idx, logic [31:0] w);
        add_access(1'b0, SEL_INDEX, idx, 1'b0, 1'b0);
        add_access(1'b0, SEL_HIGH, w[15:8], 1'b0, 1'b0);
        add_access(1'b0, SEL_LOW, w[7:0], 1'b0, 1'b0);
        add_access(1'b0, SEL_INDEX, idx + 8'd1, 1'b0, 1'b0);
        add_access(1'b0, SEL_HIGH, w[31:24], 1'b0, 1'b0);
        add_access(1'b0, SEL_LOW, w[23:16], 1'b0, 1'b0);
    endfunction

    // Launch the command, request status and advance to the next phrase
    function automatic void add_launch(logic ending);
        seq_addr   = seq_addr + PHRASE_STEP;
        seq_ending = ending;
        add_access(1'b0, SEL_STATUS, ST_LAUNCH, 1'b0, 1'b0);
        add_access(1'b1, SEL_STATUS, ST_NONE, 1'b0, 1'b0);
        seq_phase = PH_POLL;
    endfunction

    // Advance the sequencer copy by one accepted item and queue its accesses
    function automatic void predict_accesses(logic func, logic [31:0] word, logic last,
                                             logic [7:0] st);
        case (seq_phase)
            PH_INIT:
            begin
                if (func == FUNC_STATUS)
                begin
                    if (!st[ST_READY_BIT])
                    begin
                        add_access(1'b1, SEL_STATUS, ST_NONE, 1'b0, 1'b0);
                    end
                    else
                    begin
                        if ((st & ST_ERRORS) != 8'd0)
                            add_access(1'b0, SEL_STATUS, ST_ERRORS, 1'b0, 1'b0);
                        seq_addr   = cfg_start;
                        seq_ending = 1'b0;
                        seq_phase  = PH_FIRST;
                    end
                end
            end
            PH_FIRST:
            begin
                if (func == FUNC_DATA)
                begin
                    add_access(1'b0, SEL_INDEX, IDX_ADDR_HI, 1'b0, 1'b0);
                    add_access(1'b0, SEL_HIGH, CMD_PROGRAM, 1'b0, 1'b0);
                    add_access(1'b0, SEL_LOW, seq_addr[23:16], 1'b0, 1'b0);
                    add_access(1'b0, SEL_INDEX, IDX_ADDR_LO, 1'b0, 1'b0);
                    add_access(1'b0, SEL_HIGH, seq_addr[15:8], 1'b0, 1'b0);
                    add_access(1'b0, SEL_LOW, seq_addr[7:0], 1'b0, 1'b0);
                    add_word(IDX_WORD0, word);
                    if (last)
                        add_launch(1'b1);
                    else
                        seq_phase = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (func == FUNC_DATA)
                begin
                    add_word(IDX_WORD1, word);
                    add_launch(last);
                end
            end
            PH_POLL:
            begin
                if (func == FUNC_STATUS)
                begin
                    if (!st[ST_READY_BIT])
                    begin
                        add_access(1'b1, SEL_STATUS, ST_NONE, 1'b0, 1'b0);
                    end
                    else if ((st & ST_ERRORS) != 8'd0)
                    begin
                        add_access(1'b0, SEL_STATUS, ST_NONE, 1'b1, 1'b1);
                        seq_phase = PH_DONE;
                    end
                    else if (seq_ending)
                    begin
                        add_access(1'b0, SEL_STATUS, ST_NONE, 1'b1, 1'b0);
                        seq_phase = PH_DONE;
                    end
                    else
                    begin
                        seq_phase = PH_FIRST;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Mark the final access of this item and hand the run to the checker
        if (item_accesses.size() > 0)
            item_accesses[item_accesses.size() - 1].run_last = 1'b1;
        foreach (item_accesses[i])
            expected_accesses.push_back(item_accesses[i]);
        item_accesses.delete();
    endfunction

    function automatic logic [7:0] not_ready_status();
        logic [7:0] r;
        r = 8'($urandom);
        r[ST_READY_BIT] = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] ready_clean_status();
        logic [7:0] r;
        r = 8'($urandom);
        r[ST_READY_BIT]  = 1'b1;
        r[ST_ACCERR_BIT] = 1'b0;
        r[ST_FPVIOL_BIT] = 1'b0;
        return r;
    endfunction

    // Send one input item after a random gap; the unused field carries noise
    task automatic send_item(input logic func, input logic [31:0] word, input logic last,
                             input logic [7:0] st);
        int         gap;
        logic [31:0] word_drv;
        logic [7:0]  st_drv;
        begin
            gap      = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            word_drv = (func == FUNC_DATA) ? word : $urandom;
            st_drv   = (func == FUNC_STATUS) ? st : 8'($urandom);
            @(negedge clk);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {st_drv, word_drv};
            s_tuser  <= func;
            s_tlast  <= last;
            do @(posedge clk); while (!s_tready);
            predict_accesses(func, word_drv, last, st_drv);
            items_accepted++;
        end
    endtask

    // Drop valid and let every pending access drain, then settle
    task automatic wait_idle();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (expected_accesses.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_start_address(input logic [ADDR_W-1:0] value);
        begin
            @(negedge clk);
            cfg_wen   <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_wen   <= 1'b0;
            cfg_start = value;
        end
    endtask

    // Initial status check with several start addresses written while it polls
    task automatic test_start_address();
        begin
            write_start_address(24'h000000);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'h7F);
            send_item(FUNC_DATA, 32'hFFFF_FFFF, 1'b1, 8'd0);
            wait_idle();
            write_start_address(24'hFFFFFF);
            send_item(FUNC_STATUS, 32'd0, 1'b1, 8'h00);
            wait_idle();
            // Start near the top so the phrase address wraps during the run
            write_start_address(24'hFFFF00 | 24'($urandom_range(0, 255)));
            send_item(FUNC_STATUS, 32'd0, 1'b0,
                      ($urandom_range(0, 1) == 1) ? 8'hFF : ready_clean_status());
        end
    endtask

    // Word extremes, polling and items of the wrong kind
    task automatic test_directed_runs();
        begin
            send_item(FUNC_STATUS, 32'd0, 1'b1, 8'hFF);
            send_item(FUNC_DATA, 32'h0000_0000, 1'b0, 8'd0);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'h00);
            send_item(FUNC_DATA, 32'hFFFF_FFFF, 1'b0, 8'd0);
            send_item(FUNC_DATA, 32'hFFFF_FFFF, 1'b1, 8'd0);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'h7F);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'h00);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'hCF);
            send_item(FUNC_DATA, 32'h1234_5678, 1'b0, 8'd0);
            send_item(FUNC_DATA, 32'h89AB_CDEF, 1'b0, 8'd0);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'h80);
        end
    endtask

    // Mostly well-formed word pairs and polls, with some wrong-kind noise
    task automatic test_random_traffic();
        int counted;
        int pick;
        begin
            counted = 0;
            while (counted < RANDOM_ITEMS)
            begin
                if (counted % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (seq_phase == PH_POLL)
                begin
                    if (pick < 12)
                    begin
                        send_item(FUNC_DATA, $urandom, 1'($urandom_range(0, 1)), 8'd0);
                    end
                    else
                    begin
                        if (pick < 40)
                            send_item(FUNC_STATUS, 32'd0, 1'($urandom_range(0, 1)),
                                      not_ready_status());
                        else
                            send_item(FUNC_STATUS, 32'd0, 1'($urandom_range(0, 1)),
                                      ready_clean_status());
                        counted++;
                    end
                end
                else
                begin
                    if (pick < 10)
                    begin
                        send_item(FUNC_STATUS, 32'd0, 1'($urandom_range(0, 1)),
                                  8'($urandom));
                    end
                    else
                    begin
                        send_item(FUNC_DATA, $urandom, 1'b0, 8'd0);
                        counted++;
                    end
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // Finish the block by a final word or an error, then confirm it ignores input
    task automatic test_block_end();
        logic [7:0] st;
        begin
            end_kind   = block_end_t'($urandom_range(0, 2));
            end_failed = (end_kind == END_ERROR) ? 1'b1 : 1'($urandom_range(0, 1));
            if (seq_phase == PH_SECOND)
                send_item(FUNC_DATA, $urandom, 1'b0, 8'd0);
            if (seq_phase == PH_POLL)
                send_item(FUNC_STATUS, 32'd0, 1'b0, ready_clean_status());
            case (end_kind)
                END_ODD_WORD:
                begin
                    send_item(FUNC_DATA, $urandom, 1'b1, 8'd0);
                end
                END_WORD_PAIR:
                begin
                    send_item(FUNC_DATA, $urandom, 1'b0, 8'd0);
                    send_item(FUNC_DATA, $urandom, 1'b1, 8'd0);
                end
                default:
                begin
                    send_item(FUNC_DATA, $urandom, 1'b0, 8'd0);
                    send_item(FUNC_DATA, $urandom, 1'b0, 8'd0);
                end
            endcase
            send_item(FUNC_STATUS, 32'd0, 1'b0, not_ready_status());
            if (end_failed)
            begin
                st = ready_clean_status();
                st[ST_FPVIOL_BIT + 1 -: 2] = 2'($urandom_range(1, 3));
            end
            else
            begin
                st = ready_clean_status();
            end
            send_item(FUNC_STATUS, 32'd0, 1'b0, st);
            // Everything after completion is dropped
            send_item(FUNC_DATA, $urandom, 1'b1, 8'd0);
            send_item(FUNC_STATUS, 32'd0, 1'b0, 8'hFF);
            send_item(FUNC_STATUS, 32'd0, 1'b1, 8'h80);
            send_item(FUNC_DATA, 32'd0, 1'b0, 8'd0);
        end
    endtask

    // Accept bus accesses with random stalls and compare against the prediction
    initial
    begin : access_checker
        int          stall;
        bus_access_t exp;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            accesses_checked++;
            if (expected_accesses.size() == 0)
            begin
                $error("unexpected bus access: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end
            else
            begin
                exp = expected_accesses.pop_front();
                if (m_tuser !== exp.is_read)
                begin
                    $error("is_read expected %0h actual %0h", exp.is_read, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[1:0] !== exp.reg_select)
                begin
                    $error("reg_select expected %0h actual %0h", exp.reg_select,
                           m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[9:2] !== exp.write_byte)
                begin
                    $error("write_byte expected %0h actual %0h", exp.write_byte,
                           m_tdata[9:2]);
                    mismatch_count++;
                end
                if (m_tlast !== exp.run_last)
                begin
                    $error("run_last expected %0h actual %0h", exp.run_last, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[10] !== exp.finished)
                begin
                    $error("finished expected %0h actual %0h", exp.finished, m_tdata[10]);
                    mismatch_count++;
                end
                if (m_tdata[11] !== exp.failed)
                begin
                    $error("failed expected %0h actual %0h", exp.failed, m_tdata[11]);
                    mismatch_count++;
                end
            end
            @(negedge clk);
        end
    end

    // End the run when neither stream moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[flash_phrase_program_sequencer] ERROR");
        $finish;
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n            = 1'b0;
        cfg_wen          = 1'b0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        s_tlast          = 1'b0;
        seq_phase        = PH_INIT;
        seq_addr         = '0;
        seq_ending       = 1'b0;
        cfg_start        = '0;
        no_idle          = 1'b0;
        mismatch_count   = 0;
        items_accepted   = 0;
        accesses_checked = 0;
        end_kind         = END_ERROR;
        end_failed       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_start_address();
        test_directed_runs();
        test_random_traffic();
        test_block_end();
        wait_idle();

        $display("Covered %0d input items and %0d bus accesses over one programmed block,",
                 items_accepted, accesses_checked);
        $display("ended by %s with failed = %0d", end_kind.name(), end_failed);
        if (mismatch_count == 0)
            $display("[flash_phrase_program_sequencer] OK");
        else
            $display("[flash_phrase_program_sequencer] ERROR");
        $finish;
    end

endmodule
